// ===== hw/rtl/vked_pkg.sv =====
// Shared types and constants for the VT100 key escape decoder.
package vked_pkg;

    localparam logic [7:0]  ESC_BYTE     = 8'd27;
    localparam logic [7:0]  CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0]  CHAR_TILDE   = 8'h7E;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam logic [7:0]  CHAR_LF      = 8'h0A;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_D = 8'h44;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_ONE     = 8'h31;
    localparam logic [7:0]  CHAR_SIX     = 8'h36;
    localparam logic [7:0]  CHAR_NINE    = 8'h39;
    localparam logic [15:0] SPECIAL_FLAG = 16'h8000;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ESC     = 3'd1,
        PH_BRACKET = 3'd2,
        PH_DIGIT1  = 3'd3,
        PH_DIGIT2  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_SPECIAL = 2'd1,
        KIND_CHAR    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
    } t_cmd;

endpackage

// ===== hw/rtl/vt100_key_escape_decoder.sv =====
// Top level of the VT100 key escape decoder.
// Takes one received byte per beat and gives exactly one result beat per byte, in order:
// a key code (zero for none, bit 15 set for arrow and tilde keys, otherwise the character
// with CR turned into LF) and an optional echo byte. Bytes are accepted one per cycle while
// full is low; the front end classifies each byte in the cycle it is accepted, a two-entry
// queue carries it to the back end, and the result is loaded into the output register
// once that register is empty or being popped, and stays on the result ports until popped.
// The sustained rate is one byte per cycle as long as results
// are popped; while they are not, three bytes are held before full rises. The echo enable
// register resets to one and should be written only while no byte or result is pending.
module vt100_key_escape_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] o_key_code,
    output logic        o_echo_valid,
    output logic [7:0]  o_echo_byte
);

    vked_pkg::t_cmd w_front_cmd;
    vked_pkg::t_cmd w_queue_cmd;
    logic           w_accept;
    logic           w_queue_empty;
    logic           w_queue_pop;

    assign w_accept = push && !full;

    vked_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_cmd     (w_front_cmd)
    );

    vked_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_queue_pop),
        .o_empty (w_queue_empty),
        .o_data  (w_queue_cmd)
    );

    vked_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd_empty  (w_queue_empty),
        .i_cmd        (w_queue_cmd),
        .o_cmd_pop    (w_queue_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_key_code   (o_key_code),
        .o_echo_valid (o_echo_valid),
        .o_echo_byte  (o_echo_byte)
    );

endmodule

// ===== hw/rtl/vked_front.sv =====
// Front end: tracks the escape sequence state and classifies each received byte.
module vked_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output vked_pkg::t_cmd o_cmd
);

    vked_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_key, n_key;
    logic [7:0]       w_char;
    logic [7:0]       w_digit;

    assign w_digit = i_rx_byte - vked_pkg::CHAR_ZERO;
    assign w_char  = (i_rx_byte == vked_pkg::CHAR_CR) ? vked_pkg::CHAR_LF : i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vked_pkg::PH_IDLE;
            r_key   <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_key   <= n_key;
        end
    end

    always_comb begin
        n_phase     = vked_pkg::PH_IDLE;
        n_key       = r_key;
        o_cmd.kind  = vked_pkg::KIND_NONE;
        o_cmd.value = 16'd0;
        if (i_rx_byte == 8'd0) begin
            n_phase = r_phase;
        end else if (i_rx_byte == vked_pkg::ESC_BYTE) begin
            n_phase = vked_pkg::PH_ESC;
        end else if (r_phase == vked_pkg::PH_ESC && i_rx_byte == vked_pkg::CHAR_LBRACK) begin
            n_phase = vked_pkg::PH_BRACKET;
        end else if (r_phase == vked_pkg::PH_BRACKET && i_rx_byte >= vked_pkg::CHAR_UPPER_A
                     && i_rx_byte <= vked_pkg::CHAR_UPPER_D) begin
            o_cmd.kind  = vked_pkg::KIND_SPECIAL;
            o_cmd.value = vked_pkg::SPECIAL_FLAG
                          | {8'd0, i_rx_byte - vked_pkg::CHAR_UPPER_A + 8'd1};
        end else if (r_phase == vked_pkg::PH_BRACKET && i_rx_byte >= vked_pkg::CHAR_ONE
                     && i_rx_byte <= vked_pkg::CHAR_SIX) begin
            n_phase = vked_pkg::PH_DIGIT1;
            n_key   = w_digit;
        end else if (r_phase == vked_pkg::PH_DIGIT1) begin
            if (i_rx_byte == vked_pkg::CHAR_TILDE) begin
                o_cmd.kind  = vked_pkg::KIND_SPECIAL;
                o_cmd.value = vked_pkg::SPECIAL_FLAG | {r_key, 8'd0};
            end else if (i_rx_byte >= vked_pkg::CHAR_ZERO && i_rx_byte <= vked_pkg::CHAR_NINE) begin
                n_phase = vked_pkg::PH_DIGIT2;
                n_key   = {r_key[3:0], w_digit[3:0]};
            end
        end else if (r_phase == vked_pkg::PH_DIGIT2) begin
            if (i_rx_byte == vked_pkg::CHAR_TILDE) begin
                o_cmd.kind  = vked_pkg::KIND_SPECIAL;
                o_cmd.value = vked_pkg::SPECIAL_FLAG | {8'd0, r_key};
            end
        end else begin
            o_cmd.kind  = vked_pkg::KIND_CHAR;
            o_cmd.value = {8'd0, w_char};
        end
    end

endmodule

// ===== hw/rtl/vked_fifo.sv =====
// Two-entry command queue between the front and back ends.
module vked_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vked_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output vked_pkg::t_cmd o_data
);

    vked_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/vked_back.sv =====
// Back end: turns commands into key codes and echo beats in an output register.
module vked_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_cmd_empty,
    input  vked_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [15:0]    o_key_code,
    output logic           o_echo_valid,
    output logic [7:0]     o_echo_byte
);

    logic        r_echo_enable;
    logic        r_valid;
    logic [15:0] r_key_code;
    logic        r_echo_valid;
    logic [7:0]  r_echo_byte;
    logic        w_echo;

    assign o_cmd_pop    = !i_cmd_empty && (!r_valid || i_pop);
    assign w_echo       = (i_cmd.kind == vked_pkg::KIND_CHAR) && r_echo_enable;
    assign o_empty      = !r_valid;
    assign o_key_code   = r_key_code;
    assign o_echo_valid = r_echo_valid;
    assign o_echo_byte  = r_echo_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_enable <= 1'b1;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_echo_enable <= i_cfg_wdata;
            end
            if (o_cmd_pop) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_key_code   <= i_cmd.value;
            r_echo_valid <= w_echo;
            r_echo_byte  <= w_echo ? i_cmd.value[7:0] : 8'd0;
        end
    end

endmodule

// ===== hw/rtl/vked_checker.sv =====
// Port-level checker for the VT100 key escape decoder and its bind statement.
module vked_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_key_code,
    input logic        o_echo_valid,
    input logic [7:0]  o_echo_byte
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("Queue not empty after reset.");

    a_echo_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_echo_valid |-> o_key_code[15:8] == 8'd0 && o_echo_byte == o_key_code[7:0])
        else $error("Echo byte does not match the character.");

    a_no_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_echo_valid |-> o_echo_byte == 8'd0)
        else $error("Echo byte not zero without echo.");

    a_special_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_key_code[15] |-> !o_echo_valid)
        else $error("Special key was echoed.");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_key_code) && $stable(o_echo_valid))
        else $error("Waiting result changed.");

endmodule

bind vt100_key_escape_decoder vked_checker u_vked_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_key_code   (o_key_code),
    .o_echo_valid (o_echo_valid),
    .o_echo_byte  (o_echo_byte)
);
